/* rtl/core/ima_pkg.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decoder package
// Shared types, constants, step-size table and index-adjust function.
// ----------------------------------------------------------------------------
package ima_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 7;
   localparam int SIZE_W   = 15;

   localparam logic [STEP_W-1:0] STEP_MAX = 7'd88;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      VAR_SCALED     = 2'd0,
      VAR_SHIFT_ADD  = 2'd1,
      VAR_STEP_FIRST = 2'd2,
      VAR_ALT_SHIFT  = 2'd3
   } variant_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic [3:0]                  nibble;
      logic signed [SAMPLE_W-1:0]  header_history;
      logic signed [SAMPLE_W-1:0]  header_step;
   } item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  sample;
      logic [STEP_W-1:0]           step_idx;
   } result_type;

   localparam logic [SIZE_W-1:0] STEP_TABLE [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   function automatic logic [SIZE_W-1:0] step_size(input logic [STEP_W-1:0] idx);
      logic [STEP_W-1:0] i;
      i = (idx > STEP_MAX) ? STEP_MAX : idx;
      return STEP_TABLE[i];
   endfunction

   function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
      logic signed [4:0] adj;
      unique case (mag)
         3'd0, 3'd1, 3'd2, 3'd3: adj = -5'sd1;
         3'd4:                   adj = 5'sd2;
         3'd5:                   adj = 5'sd4;
         3'd6:                   adj = 5'sd6;
         default:                adj = 5'sd8;
      endcase
      return adj;
   endfunction

endpackage

/* rtl/core/ima_decode.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM decode datapath
// Next history and step index for one word, all four delta rules.
// ----------------------------------------------------------------------------
module ima_decode (
   input  ima_pkg::item_type    item,
   input  ima_pkg::result_type  state,
   input  ima_pkg::variant_type variant,
   output ima_pkg::result_type  result
);
   import ima_pkg::*;

   logic [2:0]               mag;
   logic                     neg;
   logic signed [4:0]        adj;
   logic signed [8:0]        idx_sum;
   logic [STEP_W-1:0]        idx_new;
   logic [STEP_W-1:0]        hdr_idx;
   logic [SIZE_W-1:0]        step;
   logic [SIZE_W+2:0]        prod;
   logic [18:0]              delta;
   logic signed [21:0]       base;
   logic signed [21:0]       sum;
   logic signed [21:0]       pre;
   logic signed [SAMPLE_W-1:0] sat;

   assign mag = item.nibble[2:0];
   assign neg = item.nibble[3];
   assign adj = index_adjust(mag);

   always_comb begin
      idx_sum = $signed({2'b00, state.step_idx}) + {{4{adj[4]}}, adj};
      if (idx_sum[8]) begin
         idx_new = '0;
      end else if (idx_sum > $signed({2'b00, STEP_MAX})) begin
         idx_new = STEP_MAX;
      end else begin
         idx_new = idx_sum[STEP_W-1:0];
      end

      if (item.header_step[SAMPLE_W-1]) begin
         hdr_idx = '0;
      end else if (item.header_step > $signed({9'd0, STEP_MAX})) begin
         hdr_idx = STEP_MAX;
      end else begin
         hdr_idx = item.header_step[STEP_W-1:0];
      end
   end

   // step-first rule looks up the updated index
   assign step = (variant == VAR_STEP_FIRST) ? step_size(idx_new) : step_size(state.step_idx);
   assign prod = {3'b000, step} * {{SIZE_W{1'b0}}, mag};

   always_comb begin
      unique case (variant)
         VAR_SCALED: begin
            delta = {prod, 1'b0} + {4'd0, step};
         end
         VAR_SHIFT_ADD: begin
            delta = {7'd0, step[SIZE_W-1:3]}
                  + (item.nibble[0] ? {6'd0, step[SIZE_W-1:2]} : 19'd0)
                  + (item.nibble[1] ? {5'd0, step[SIZE_W-1:1]} : 19'd0)
                  + (item.nibble[2] ? {4'd0, step} : 19'd0);
         end
         VAR_STEP_FIRST: begin
            delta = {3'd0, prod[SIZE_W+2:2]} + {7'd0, step[SIZE_W-1:3]};
         end
         default: begin
            delta = {3'd0, prod[SIZE_W+2:2]};
         end
      endcase
   end

   always_comb begin
      if (variant == VAR_SCALED) begin
         base = {{3{state.sample[SAMPLE_W-1]}}, state.sample, 3'b000};
      end else begin
         base = {{6{state.sample[SAMPLE_W-1]}}, state.sample};
      end
      sum = neg ? (base - $signed({3'b000, delta})) : (base + $signed({3'b000, delta}));
      pre = (variant == VAR_SCALED) ? (sum >>> 3) : sum;
      if (pre > 22'sd32767) begin
         sat = 16'sh7fff;
      end else if (pre < -22'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = pre[SAMPLE_W-1:0];
      end

      if (item.opcode == OP_LOAD) begin
         result.sample   = item.header_history;
         result.step_idx = hdr_idx;
      end else begin
         result.sample   = sat;
         result.step_idx = idx_new;
      end
   end

endmodule

/* rtl/core/ima_adpcm_nibble_decoder_unit.sv */
// ----------------------------------------------------------------------------
// IMA ADPCM nibble decoder unit
// Decodes 4-bit ADPCM codes or loads block headers into 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Use:
//   req_* carries one word per code: opcode, nibble and the header fields.
//   rsp_* returns one word per request: the sample and the step index after it.
//   csr_write_en / csr_write_data select the delta rule; write only when idle.
// Timing:
//   A request word is registered, decoded in one pass through the step table,
//   one small multiplier and a saturating add, and lands in the result
//   register, which drives rsp_valid. One word per cycle sustained while
//   rsp_ready is high; the history and step index are updated in the
//   same cycle the result is registered, so consecutive words chain.
// Stalls:
//   If rsp_ready is low the result holds; one further word waits in the
//   input register and req_ready drops until the result is taken.
// Reset:
//   Clears both valid flags, history and step index to zero, delta rule to 1.
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic [3:0]                            req_nibble,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]   req_header_history,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]   req_header_step,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ima_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic [ima_pkg::STEP_W-1:0]            rsp_step_out,
   input  logic                                  csr_write_en,
   input  logic [1:0]                            csr_write_data
);
   import ima_pkg::*;

   logic        in_valid_ff, in_valid_in;
   item_type    item_ff, item_in;
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff, result_in;
   result_type  state_ff, state_in;
   variant_type variant_ff, variant_in;
   result_type  decoded;
   logic        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ima_decode u_decode (
      .item    (item_ff),
      .state   (state_ff),
      .variant (variant_ff),
      .result  (decoded)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      item_in      = item_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      state_in     = state_ff;
      variant_in   = variant_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         item_in     = '{opcode: opcode_type'(req_opcode), nibble: req_nibble,
                         header_history: req_header_history,
                         header_step: req_header_step};
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = decoded;
         state_in     = decoded;
      end
      if (csr_write_en) begin
         variant_in = variant_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         variant_ff   <= VAR_SHIFT_ADD;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         variant_ff   <= variant_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = result_ff.sample;
   assign rsp_step_out   = result_ff.step_idx;

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.step_idx <= STEP_MAX)
      else $error("step index out of range");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff == state_ff))
      else $error("pending result differs from decoder state");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word lost");

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> (in_valid_ff && $stable(item_ff)))
      else $error("waiting word dropped");
`endif

endmodule
